@@ hw/rtl/cdsc_pkg.sv @@
// Shared types and constants for the charger duty step controller.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package cdsc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_TARGET_VOLTAGE   = 3'd0;
	localparam logic [2:0] REG_TARGET_CURRENT   = 3'd1;
	localparam logic [2:0] REG_CONTROL_MODE     = 3'd2;
	localparam logic [2:0] REG_DUTY_LIMIT       = 3'd3;
	localparam logic [2:0] REG_ERROR_DEADBAND   = 3'd4;
	localparam logic [2:0] REG_SHORT_RES_LIMIT  = 3'd5;

	// Regulation modes
	localparam logic [1:0] MODE_VOLTAGE = 2'd1;
	localparam logic [1:0] MODE_CURRENT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [14:0] RST_TARGET_VOLTAGE  = 15'd0;
	localparam logic [14:0] RST_TARGET_CURRENT  = 15'd0;
	localparam logic [1:0]  RST_CONTROL_MODE    = 2'd0;
	localparam logic [8:0]  RST_DUTY_LIMIT      = 9'd284;
	localparam logic [14:0] RST_ERROR_DEADBAND  = 15'd250;
	localparam logic [15:0] RST_SHORT_RES_LIMIT = 16'd200;

	// Duty scale and protection constants
	localparam logic [8:0]  DUTY_FULL     = 9'd310;
	localparam logic [8:0]  PROT_MIN_DUTY = 9'd10;
	localparam logic [9:0]  RES_SCALE     = 10'd1000;

	// duty * 100 / 310 as (duty * PCT_MUL) >> PCT_SHIFT, exact for duty <= 310
	localparam logic [15:0] PCT_MUL   = 16'd42290;
	localparam int          PCT_SHIFT = 17;

	typedef struct packed {
		logic [14:0] measured_voltage;
		logic [14:0] measured_current;
		logic        toggle_request;
	} sample_t;

	typedef struct packed {
		logic [8:0] duty_level;
		logic [6:0] duty_percent;
		logic       relay_on;
		logic       running_flag;
		logic       fault_flag;
		logic       steady_flag;
	} result_t;

	typedef struct packed {
		logic [14:0] target_voltage;
		logic [14:0] target_current;
		logic [1:0]  control_mode;
		logic [8:0]  duty_limit;
		logic [14:0] error_deadband;
		logic [15:0] short_resistance_limit;
	} cfg_t;

	// Per-sample decisions handed from the front stage to the state update
	typedef struct packed {
		logic regulate;   // a regulation mode is selected
		logic step_up;    // error above the deadband
		logic step_down;  // error below minus the deadband
		logic low_res;    // load resistance at or below the limit
		logic press;      // start/stop press
	} step_t;

endpackage

@@ hw/rtl/cdsc_regs.sv @@
// Configuration register file of the charger duty step controller.
// Depends on cdsc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module cdsc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output cdsc_pkg::cfg_t      cfg
);

	cdsc_pkg::cfg_t cfg_q;

	// Always take a write beat; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_voltage         <= cdsc_pkg::RST_TARGET_VOLTAGE;
			cfg_q.target_current         <= cdsc_pkg::RST_TARGET_CURRENT;
			cfg_q.control_mode           <= cdsc_pkg::RST_CONTROL_MODE;
			cfg_q.duty_limit             <= cdsc_pkg::RST_DUTY_LIMIT;
			cfg_q.error_deadband         <= cdsc_pkg::RST_ERROR_DEADBAND;
			cfg_q.short_resistance_limit <= cdsc_pkg::RST_SHORT_RES_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cdsc_pkg::REG_TARGET_VOLTAGE:  cfg_q.target_voltage <= cfg_data[14:0];
				cdsc_pkg::REG_TARGET_CURRENT:  cfg_q.target_current <= cfg_data[14:0];
				cdsc_pkg::REG_CONTROL_MODE:    cfg_q.control_mode   <= cfg_data[1:0];
				cdsc_pkg::REG_DUTY_LIMIT:      cfg_q.duty_limit     <= cfg_data[8:0];
				cdsc_pkg::REG_ERROR_DEADBAND:  cfg_q.error_deadband <= cfg_data[14:0];
				cdsc_pkg::REG_SHORT_RES_LIMIT: cfg_q.short_resistance_limit <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/cdsc_front.sv @@
// Input register and per-sample decisions (resistance check, error compares).
// Depends on cdsc_pkg for sample_t, cfg_t, step_t and constants.
`timescale 1ns / 1ps

module cdsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  cdsc_pkg::sample_t  sample,
	input  cdsc_pkg::cfg_t     cfg,
	input  logic               take,       // core takes the s2 beat this cycle
	output logic               valid_s2,
	output cdsc_pkg::step_t    step_s2
);

	cdsc_pkg::sample_t smp_s1;
	logic              valid_s1;
	logic              adv_s1;
	logic              load_s1;
	logic              free_s2;

	logic [24:0]       v_scaled;
	logic [16:0]       lim_p1;
	logic [31:0]       c_bound;
	logic [16:0]       tv_w, tc_w, v_w, c_w, db_w;
	logic              up_v, dn_v, up_c, dn_c;
	cdsc_pkg::step_t   step_d;

	// Stage handshake: each stage fills when empty or when it drains
	assign free_s2      = !valid_s2 || take;
	assign adv_s1       = valid_s1 && free_s2;
	assign load_s1      = !valid_s1 || adv_s1;
	assign sample_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= sample_valid;
			end
			if (free_s2) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid) begin
			smp_s1 <= sample;
		end
		if (adv_s1) begin
			step_s2 <= step_d;
		end
	end

	// Resistance check: floor(v*1000/c) <= L  <=>  v*1000 < (L+1)*c, c != 0
	always_comb begin
		v_scaled = {10'd0, smp_s1.measured_voltage} * {15'd0, cdsc_pkg::RES_SCALE};
		lim_p1   = {1'b0, cfg.short_resistance_limit} + 17'd1;
		c_bound  = {15'd0, lim_p1} * {17'd0, smp_s1.measured_current};
	end

	// Error compares without forming the signed error
	always_comb begin
		tv_w = {2'b00, cfg.target_voltage};
		tc_w = {2'b00, cfg.target_current};
		v_w  = {2'b00, smp_s1.measured_voltage};
		c_w  = {2'b00, smp_s1.measured_current};
		db_w = {2'b00, cfg.error_deadband};
		up_v = tv_w > (v_w + db_w);
		dn_v = (tv_w + db_w) < v_w;
		up_c = tc_w > (c_w + db_w);
		dn_c = (tc_w + db_w) < c_w;
	end

	always_comb begin
		step_d.regulate  = (cfg.control_mode == cdsc_pkg::MODE_VOLTAGE) ||
		                   (cfg.control_mode == cdsc_pkg::MODE_CURRENT);
		step_d.step_up   = (cfg.control_mode == cdsc_pkg::MODE_VOLTAGE) ? up_v : up_c;
		step_d.step_down = (cfg.control_mode == cdsc_pkg::MODE_VOLTAGE) ? dn_v : dn_c;
		step_d.low_res   = (smp_s1.measured_current != 15'd0) &&
		                   ({7'd0, v_scaled} < c_bound);
		step_d.press     = smp_s1.toggle_request;
	end

endmodule

@@ hw/rtl/cdsc_core.sv @@
// Controller state (duty, run, steady, fault) and the result register.
// Depends on cdsc_pkg for step_t, result_t, cfg_t and constants.
`timescale 1ns / 1ps

module cdsc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  cdsc_pkg::cfg_t     cfg,
	input  logic               valid_s2,
	input  cdsc_pkg::step_t    step_s2,
	output logic               take,
	output logic               result_valid,
	input  logic               result_stall,
	output cdsc_pkg::result_t  result
);

	logic [8:0]        duty_q;
	logic              running_q, steady_q, pending_q, latched_q;
	logic [8:0]        duty_d;
	logic              running_d, steady_d, pending_d, latched_d;
	logic [8:0]        lim;
	logic              stop;
	logic [8:0]        level;
	logic [23:0]       pct_prod;
	cdsc_pkg::result_t res_d;
	cdsc_pkg::result_t res_q;

	// Result register drains or is empty: take the next beat
	assign take   = valid_s2 && (!result_valid || !result_stall);
	assign result = res_q;

	assign lim = (cfg.duty_limit > cdsc_pkg::DUTY_FULL) ? cdsc_pkg::DUTY_FULL
	                                                   : cfg.duty_limit;

	// Next state: protection, then stepping, then start/stop
	always_comb begin
		duty_d    = duty_q;
		running_d = running_q;
		steady_d  = steady_q;
		pending_d = pending_q;
		latched_d = latched_q;
		stop      = step_s2.press;
		if (running_q) begin
			if (duty_q > cdsc_pkg::PROT_MIN_DUTY) begin
				if (step_s2.low_res && pending_q) begin
					latched_d = 1'b1;
					stop      = 1'b1;
				end else if (step_s2.low_res) begin
					pending_d = 1'b1;
				end else begin
					pending_d = 1'b0;
				end
			end
			if (!latched_d && step_s2.regulate) begin
				if (step_s2.step_up && (duty_q < lim)) begin
					duty_d = duty_q + 9'd1;
				end else if (step_s2.step_down && (duty_q != 9'd0)) begin
					duty_d = duty_q - 9'd1;
				end else begin
					steady_d = 1'b1;
				end
			end
		end
		if (latched_d) begin
			pending_d = 1'b0;
		end
		if (stop) begin
			if (!running_q) begin
				running_d = !latched_d;
			end else begin
				running_d = 1'b0;
				steady_d  = 1'b0;
				duty_d    = 9'd0;
			end
		end
	end

	// Result fields; percent by reciprocal multiply
	always_comb begin
		level              = latched_d ? 9'd0 : duty_d;
		pct_prod           = 24'({15'd0, level} * {8'd0, cdsc_pkg::PCT_MUL});
		res_d.duty_level   = level;
		res_d.duty_percent = pct_prod[cdsc_pkg::PCT_SHIFT +: 7];
		res_d.relay_on     = running_d;
		res_d.running_flag = running_d;
		res_d.fault_flag   = latched_d;
		res_d.steady_flag  = steady_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q       <= 9'd0;
			running_q    <= 1'b0;
			steady_q     <= 1'b0;
			pending_q    <= 1'b0;
			latched_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (take) begin
				duty_q    <= duty_d;
				running_q <= running_d;
				steady_q  <= steady_d;
				pending_q <= pending_d;
				latched_q <= latched_d;
			end
			if (!result_valid || !result_stall) begin
				result_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	// A latched fault stops the charger for good
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q |-> !running_q)
		else $error("running while a fault is latched");

	// Pending is dropped once the fault latches
	a_fault_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q |-> !pending_q)
		else $error("pending fault kept after latch");

	// Duty never leaves the full-scale range
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= cdsc_pkg::DUTY_FULL)
		else $error("duty above full scale");

	// A faulted result carries no duty and no relay drive
	a_fault_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res_q.fault_flag) |->
		(res_q.duty_level == 9'd0) && !res_q.relay_on)
		else $error("faulted result drives duty or relay");

	// State moves only when a beat is taken
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(duty_q) && $stable(running_q) && $stable(latched_q))
		else $error("state changed without a beat");

endmodule

@@ hw/rtl/charger_duty_step_controller.sv @@
// Top level of the charger duty step controller: config registers, front stage, core.
// Depends on cdsc_pkg, cdsc_regs, cdsc_front and cdsc_core.
//
//   channel  | handshake                    | beat
//   ---------+------------------------------+----------------------------------
//   sample   | sample_valid / sample_stall  | cdsc_pkg::sample_t
//   result   | result_valid / result_stall  | cdsc_pkg::result_t
//   cfg      | cfg_valid / cfg_ready        | cfg_index (3b), cfg_data (16b)
//
// One sample beat per cycle while sample_stall is low; each yields one result beat
// through the input register, the decision register and the result register.
// The resistance multiply and the error compares sit in the decision stage; the
// state update and the percent multiply feed the result register.
// Reset clears the controller state and loads the register reset values.
// A stalled result holds; the two front stages keep filling until both are full.
`timescale 1ns / 1ps

module charger_duty_step_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  cdsc_pkg::sample_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output cdsc_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cdsc_pkg::cfg_t  cfg;
	cdsc_pkg::step_t step_s2;
	logic            valid_s2;
	logic            take;

	cdsc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cdsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg          (cfg),
		.take         (take),
		.valid_s2     (valid_s2),
		.step_s2      (step_s2)
	);

	cdsc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s2     (valid_s2),
		.step_s2      (step_s2),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ tb/charger_duty_step_controller_tb.sv @@
// Self-checking testbench for the charger duty step controller.
// Depends on cdsc_pkg and the charger_duty_step_controller RTL; predicts every result beat.
`timescale 1ns / 1ps

module charger_duty_step_controller_tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 88;
	localparam int MEAS_MAX = 32767;

	// Index values that address no register, and the two modes with no regulation
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_OFF_ALT = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	cdsc_pkg::sample_t sample_beat = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cdsc_pkg::result_t result_beat;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predicted controller settings
	logic [14:0] set_voltage = cdsc_pkg::RST_TARGET_VOLTAGE;
	logic [14:0] set_current = cdsc_pkg::RST_TARGET_CURRENT;
	logic [1:0] reg_mode = cdsc_pkg::RST_CONTROL_MODE;
	logic [8:0] reg_duty_limit = cdsc_pkg::RST_DUTY_LIMIT;
	logic [14:0] reg_deadband = cdsc_pkg::RST_ERROR_DEADBAND;
	logic [15:0] reg_res_limit = cdsc_pkg::RST_SHORT_RES_LIMIT;

	// Predicted controller state
	logic [8:0] ctl_duty = '0;
	logic ctl_running = 1'b0;
	logic ctl_steady = 1'b0;
	logic prot_pending = 1'b0;
	logic prot_latched = 1'b0;

	cdsc_pkg::result_t expected_results[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;
	int long_hold_request = 0;
	int hold_left = 0;
	int stall_left = 0;

	charger_duty_step_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample_beat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_beat),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Load-resistance reading at or below the short limit; zero current reads open
	function automatic bit reads_low(int v, int c);
		if (c == 0)
			return 1'b0;
		return (v * int'(cdsc_pkg::RES_SCALE)) / c <= int'(reg_res_limit);
	endfunction

	// Step the duty one count toward the setpoint, or mark it steady
	function automatic void nudge_duty(int err);
		logic [8:0] ceiling;
		int band;
		ceiling = (reg_duty_limit > cdsc_pkg::DUTY_FULL) ? cdsc_pkg::DUTY_FULL : reg_duty_limit;
		band = int'(reg_deadband);
		if (err > band && ctl_duty < ceiling)
			ctl_duty = ctl_duty + 9'd1;
		else if (err < -band && ctl_duty != 9'd0)
			ctl_duty = ctl_duty - 9'd1;
		else
			ctl_steady = 1'b1;
	endfunction

	// Advance the controller by one sample and form its result beat
	function automatic cdsc_pkg::result_t advance_charger(cdsc_pkg::sample_t s);
		logic stop_req;
		logic low;
		logic [8:0] level;
		int v;
		int c;
		cdsc_pkg::result_t r;
		v = s.measured_voltage;
		c = s.measured_current;
		stop_req = s.toggle_request;
		if (ctl_running) begin
			// protection check, only with duty above the minimum
			if (ctl_duty > cdsc_pkg::PROT_MIN_DUTY) begin
				low = reads_low(v, c);
				if (low && prot_pending) begin
					prot_latched = 1'b1;
					stop_req = 1'b1;
				end else if (low) begin
					if (!prot_latched)
						prot_pending = 1'b1;
				end else if (prot_pending && !prot_latched) begin
					prot_pending = 1'b0;
				end
			end
			if (!prot_latched) begin
				if (reg_mode == cdsc_pkg::MODE_VOLTAGE)
					nudge_duty(int'(set_voltage) - v);
				else if (reg_mode == cdsc_pkg::MODE_CURRENT)
					nudge_duty(int'(set_current) - c);
			end
		end
		if (prot_latched)
			prot_pending = 1'b0;
		// start/stop press
		if (stop_req) begin
			if (!ctl_running) begin
				if (!prot_latched)
					ctl_running = 1'b1;
			end else begin
				ctl_running = 1'b0;
				ctl_steady = 1'b0;
				ctl_duty = '0;
			end
		end
		level = prot_latched ? 9'd0 : ctl_duty;
		r.duty_level = level;
		r.duty_percent = 7'((int'(level) * 100) / int'(cdsc_pkg::DUTY_FULL));
		r.relay_on = ctl_running;
		r.running_flag = ctl_running;
		r.fault_flag = prot_latched;
		r.steady_flag = ctl_steady;
		return r;
	endfunction

	// Hold the sender off for a random burst now and then
	task automatic pace_sender();
		if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Offer one sample beat and record its expected result once taken
	task automatic send_sample(input int v, input int c, input logic t);
		cdsc_pkg::sample_t s;
		s.measured_voltage = v[14:0];
		s.measured_current = c[14:0];
		s.toggle_request = t;
		sample_beat <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		expected_results.push_back(advance_charger(s));
		pace_sender();
	endtask

	// Keep a second low reading from latching the fault: zero current reads open
	task automatic send_guarded(input int v, input int c, input logic t);
		if (ctl_running && !prot_latched && ctl_duty > cdsc_pkg::PROT_MIN_DUTY && prot_pending
				&& reads_low(v, c))
			c = 0;
		send_sample(v, c, t);
	endtask

	// Write one register; valid stays up for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			cdsc_pkg::REG_TARGET_VOLTAGE: set_voltage = d[14:0];
			cdsc_pkg::REG_TARGET_CURRENT: set_current = d[14:0];
			cdsc_pkg::REG_CONTROL_MODE: reg_mode = d[1:0];
			cdsc_pkg::REG_DUTY_LIMIT: reg_duty_limit = d[8:0];
			cdsc_pkg::REG_ERROR_DEADBAND: reg_deadband = d[14:0];
			cdsc_pkg::REG_SHORT_RES_LIMIT: reg_res_limit = d;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every expected beat, then let the pipeline empty
	task automatic settle_pipeline();
		sample_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result stall: a requested long hold first, else random bursts
	always @(posedge clk) begin
		if (long_hold_request > 0) begin
			hold_left = long_hold_request;
			long_hold_request = 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if (receiver_stalls_on && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(1, 17) - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("%0t %s mismatch: expected %0d got %0d", $realtime, name, want, got);
		end
	endfunction

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin
		cdsc_pkg::result_t want;
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t result beat with none expected", $realtime);
			end else begin
				want = expected_results.pop_front();
				check_field("duty_level", int'(want.duty_level),
					int'(result_beat.duty_level));
				check_field("duty_percent", int'(want.duty_percent),
					int'(result_beat.duty_percent));
				check_field("relay_on", int'(want.relay_on), int'(result_beat.relay_on));
				check_field("running_flag", int'(want.running_flag),
					int'(result_beat.running_flag));
				check_field("fault_flag", int'(want.fault_flag), int'(result_beat.fault_flag));
				check_field("steady_flag", int'(want.steady_flag),
					int'(result_beat.steady_flag));
			end
		end
	end

	// Reset settings, full-scale fields, both no-regulation modes, spare indexes
	task automatic test_idle_and_extremes();
		send_sample(0, 0, 1'b0);
		send_sample(MEAS_MAX, MEAS_MAX, 1'b0);
		send_sample('h5555, 'h2AAA, 1'b1);
		send_sample('h2AAA, 'h5555, 1'b0);
		settle_pipeline();
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'h0, MODE_OFF_ALT});
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'hA5A5);
		end_writes();
		send_sample(MEAS_MAX, 0, 1'b0);
		send_sample(0, 0, 1'b1);
	endtask

	// Deadband edges, the zero floor, a zero limit, full-scale deadband
	task automatic test_step_edges();
		settle_pipeline();
		write_reg(cdsc_pkg::REG_TARGET_VOLTAGE, 16'd1000);
		write_reg(cdsc_pkg::REG_TARGET_CURRENT, 16'd32767);
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'h0, cdsc_pkg::MODE_VOLTAGE});
		end_writes();
		send_sample(500, 0, 1'b1);
		send_sample(750, 0, 1'b0);
		send_sample(749, 0, 1'b0);
		send_sample(1250, 0, 1'b0);
		send_sample(1251, 0, 1'b0);
		send_sample(1251, 0, 1'b0);
		settle_pipeline();
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, 16'd0);
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, 16'd0);
		end_writes();
		send_sample(999, 0, 1'b0);
		send_sample(1000, 0, 1'b0);
		settle_pipeline();
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'h0, cdsc_pkg::MODE_CURRENT});
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, 16'd32767);
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, 16'd310);
		end_writes();
		send_sample(0, 0, 1'b0);
		settle_pipeline();
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, 16'd32766);
		end_writes();
		send_sample(0, 0, 1'b0);
		send_sample(0, MEAS_MAX, 1'b1);
	endtask

	// Climb to full duty past a saturating limit, hold the receiver off, then
	// lower the limit under the duty and walk back down
	task automatic test_climb_to_full();
		int i;
		settle_pipeline();
		write_reg(cdsc_pkg::REG_TARGET_VOLTAGE, 16'd32767);
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'h0, cdsc_pkg::MODE_VOLTAGE});
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, 16'd511);
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, 16'd0);
		write_reg(cdsc_pkg::REG_SHORT_RES_LIMIT, 16'd0);
		end_writes();
		send_sample(0, 0, 1'b1);
		for (i = 0; i < 320; i++) begin
			if (i == 40) begin
				sender_gaps_on = 1'b0;
				long_hold_request = 90;
			end
			if (i == 80)
				sender_gaps_on = 1'b1;
			send_guarded($urandom_range(0, MEAS_MAX - 1), $urandom_range(0, MEAS_MAX), 1'b0);
		end
		settle_pipeline();
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, 16'd20);
		end_writes();
		for (i = 0; i < 5; i++)
			send_guarded($urandom_range(0, MEAS_MAX - 1), $urandom_range(0, MEAS_MAX), 1'b0);
		settle_pipeline();
		write_reg(cdsc_pkg::REG_TARGET_VOLTAGE, 16'd16000);
		end_writes();
		for (i = 0; i < 12; i++)
			send_guarded($urandom_range(16001, MEAS_MAX), $urandom_range(0, MEAS_MAX), 1'b0);
		send_sample(20000, 0, 1'b1);
	endtask

	function automatic logic [15:0] pick_setpoint();
		case ($urandom_range(0, 7))
			0: return {1'($urandom_range(0, 1)), 15'd0};
			1: return {1'($urandom_range(0, 1)), 15'd32767};
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Draw a new set of settings, extremes included
	task automatic randomize_settings();
		logic [1:0] mode;
		logic [8:0] lim;
		logic [14:0] band;
		logic [15:0] res;
		case ($urandom_range(0, 9))
			0: mode = MODE_OFF;
			1: mode = MODE_OFF_ALT;
			2, 3, 4, 5: mode = cdsc_pkg::MODE_VOLTAGE;
			default: mode = cdsc_pkg::MODE_CURRENT;
		endcase
		case ($urandom_range(0, 7))
			0: lim = 9'd0;
			1: lim = 9'd11;
			2: lim = cdsc_pkg::DUTY_FULL;
			3: lim = 9'($urandom_range(311, 511));
			4: lim = 9'd20;
			default: lim = 9'($urandom_range(0, 310));
		endcase
		case ($urandom_range(0, 15))
			0, 1: band = 15'd0;
			2: band = 15'd32767;
			default: band = 15'($urandom_range(0, 400));
		endcase
		case ($urandom_range(0, 7))
			0: res = 16'd0;
			1: res = 16'd65535;
			default: res = 16'($urandom_range(0, 2000));
		endcase
		write_reg(cdsc_pkg::REG_TARGET_VOLTAGE, pick_setpoint());
		write_reg(cdsc_pkg::REG_TARGET_CURRENT, pick_setpoint());
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'($urandom_range(0, 16383)), mode});
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, {7'($urandom_range(0, 127)), lim});
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, {1'($urandom_range(0, 1)), band});
		write_reg(cdsc_pkg::REG_SHORT_RES_LIMIT, res);
		end_writes();
	endtask

	// One sample around the setpoint, with a load resistance near the short limit
	task automatic send_random_sample(input int drift);
		int v;
		int c;
		int meas;
		int tgt;
		int spread;
		int off;
		int r_want;
		logic t;
		if ($urandom_range(0, 9) == 0) begin
			v = $urandom_range(0, MEAS_MAX);
			c = $urandom_range(0, MEAS_MAX);
			t = 1'($urandom_range(0, 1));
		end else begin
			t = ctl_running ? ($urandom_range(0, 59) == 0) : ($urandom_range(0, 2) == 0);
			tgt = (reg_mode == cdsc_pkg::MODE_CURRENT) ? int'(set_current) : int'(set_voltage);
			spread = int'(reg_deadband) + $urandom_range(1, 600);
			off = int'($urandom_range(0, spread + spread / 4)) - spread / 4;
			case (drift)
				1: meas = tgt - off;
				2: meas = tgt + off;
				default: meas = tgt + int'($urandom_range(0, 2 * spread)) - spread;
			endcase
			if (meas < 0)
				meas = 0;
			if (meas > MEAS_MAX)
				meas = MEAS_MAX;
			r_want = $urandom_range(0, 2 * int'(reg_res_limit) + 2);
			if (reg_mode == cdsc_pkg::MODE_CURRENT) begin
				c = meas;
				v = int'((longint'(c) * r_want) / 1000);
				if (v > MEAS_MAX)
					v = MEAS_MAX;
			end else begin
				v = meas;
				if (r_want == 0)
					c = $urandom_range(0, MEAS_MAX);
				else
					c = int'((longint'(v) * 1000) / r_want);
				if (c > MEAS_MAX)
					c = MEAS_MAX;
			end
		end
		send_guarded(v, c, t);
	endtask

	// Phases of random settings and drifting samples; the last phase runs unthrottled
	task automatic test_random_regulation();
		int p;
		int i;
		int drift;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle_pipeline();
			randomize_settings();
			sender_gaps_on = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
			receiver_stalls_on = (p != RANDOM_PHASES - 1) && (p % 4 != 3);
			drift = $urandom_range(0, 2);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 30 == 29)
					drift = $urandom_range(0, 2);
				send_random_sample(drift);
			end
		end
	endtask

	// Pending fault set and cleared, kept across a stop and restart, then latched
	task automatic test_short_fault();
		int i;
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		settle_pipeline();
		write_reg(cdsc_pkg::REG_TARGET_VOLTAGE, 16'd1000);
		write_reg(cdsc_pkg::REG_CONTROL_MODE, {14'h0, cdsc_pkg::MODE_VOLTAGE});
		write_reg(cdsc_pkg::REG_DUTY_LIMIT, 16'd310);
		write_reg(cdsc_pkg::REG_ERROR_DEADBAND, 16'd0);
		write_reg(cdsc_pkg::REG_SHORT_RES_LIMIT, 16'd200);
		end_writes();
		if (ctl_running)
			send_sample(100, 0, 1'b1);
		send_sample(100, 0, 1'b1);
		for (i = 0; i < 12; i++)
			send_sample(100, 0, 1'b0);
		send_sample(100, 1000, 1'b0);
		send_sample(100, 1, 1'b0);
		send_sample(200, 1000, 1'b0);
		send_sample(100, 1, 1'b0);
		for (i = 0; i < 5; i++)
			send_sample(2000, 0, 1'b0);
		send_sample(2000, 20000, 1'b0);
		send_sample(2000, 0, 1'b1);
		send_sample(100, 0, 1'b1);
		for (i = 0; i < 11; i++)
			send_sample(100, 0, 1'b0);
		send_sample(100, 1000, 1'b0);
		send_sample(100, 1000, 1'b1);
		send_sample(MEAS_MAX, MEAS_MAX, 1'b1);
		send_sample(0, 0, 1'b0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_extremes();
		test_step_edges();
		test_climb_to_full();
		test_random_regulation();
		test_short_fault();
		settle_pipeline();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
